// ===== hdl/lsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Line segment rasterizer package
// Shared widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package lsr_pkg;

    localparam int TILE_SIZE = 64;
    localparam int COORD_W   = 6;
    localparam int DEC_W     = COORD_W + 3;
    localparam int IN_W      = 4 * COORD_W;
    localparam int OUT_W     = ((2 * COORD_W + 7) / 8) * 8;

    localparam logic [COORD_W-1:0] TILE_MAX = COORD_W'(TILE_SIZE - 1);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_lsr_state;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } t_lsr_cmd;

    typedef struct packed {
        logic at_end;
    } t_lsr_stat;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] r;
        r = v;
        if (v > TILE_MAX) begin
            r = TILE_MAX;
        end
        return r;
    endfunction

endpackage

// ===== hdl/lsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Line segment rasterizer controller
// Sequences segment setup and the pixel walk, and owns the output valid flag.
// ----------------------------------------------------------------------------
module lsr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    input  lsr_pkg::t_lsr_stat i_stat,
    output lsr_pkg::t_lsr_cmd  o_cmd
);

    lsr_pkg::t_lsr_state r_state, n_state;
    logic                r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid & ~i_m_ready;
        o_s_ready      = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.out_load = 1'b0;
        case (r_state)
            lsr_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lsr_pkg::ST_WALK;
                end
            end
            lsr_pkg::ST_WALK: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    if (i_stat.at_end) begin
                        n_state = lsr_pkg::ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = lsr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_valid = r_out_valid;

endmodule

// ===== hdl/lsr_dp.sv =====
// ----------------------------------------------------------------------------
// Line segment rasterizer datapath
// Holds the Bresenham walk state and the output pixel register.
// ----------------------------------------------------------------------------
module lsr_dp (
    input  logic                         i_clk,
    input  logic [lsr_pkg::IN_W-1:0]     i_seg,
    input  lsr_pkg::t_lsr_cmd            i_cmd,
    output lsr_pkg::t_lsr_stat           o_stat,
    output logic [lsr_pkg::COORD_W-1:0]  o_pixel_x,
    output logic [lsr_pkg::COORD_W-1:0]  o_pixel_y,
    output logic                         o_last_pixel
);

    localparam int CW = lsr_pkg::COORD_W;
    localparam int DW = lsr_pkg::DEC_W;

    logic [CW-1:0]        sx, sy, ex, ey, dx, dy;
    logic                 swap;
    logic [CW-1:0]        n_major_span, n_minor_span;
    logic [CW-1:0]        r_major_pos, r_minor_pos, r_major_end;
    logic [CW-1:0]        r_major_span, r_minor_span;
    logic signed [DW-1:0] r_decision;
    logic                 r_major_down, r_minor_down, r_swapped;
    logic [CW-1:0]        r_px, r_py;
    logic                 r_last;
    logic signed [DW-1:0] minor2, major2;

    assign sx = lsr_pkg::clamp_coord(i_seg[CW-1:0]);
    assign sy = lsr_pkg::clamp_coord(i_seg[2*CW-1:CW]);
    assign ex = lsr_pkg::clamp_coord(i_seg[3*CW-1:2*CW]);
    assign ey = lsr_pkg::clamp_coord(i_seg[4*CW-1:3*CW]);
    assign dx = (sx <= ex) ? ex - sx : sx - ex;
    assign dy = (sy <= ey) ? ey - sy : sy - ey;
    assign swap = dx < dy;
    assign n_major_span = swap ? dy : dx;
    assign n_minor_span = swap ? dx : dy;

    assign minor2 = $signed({2'b00, r_minor_span, 1'b0});
    assign major2 = $signed({2'b00, r_major_span, 1'b0});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_swapped    <= swap;
            r_major_pos  <= swap ? sy : sx;
            r_minor_pos  <= swap ? sx : sy;
            r_major_end  <= swap ? ey : ex;
            r_major_span <= n_major_span;
            r_minor_span <= n_minor_span;
            r_major_down <= swap ? (sy > ey) : (sx > ex);
            r_minor_down <= swap ? (sx > ex) : (sy > ey);
            r_decision   <= $signed({2'b00, n_minor_span, 1'b0})
                          - $signed({3'b000, n_major_span});
        end else if (i_cmd.step) begin
            r_major_pos <= r_major_down ? r_major_pos - CW'(1) : r_major_pos + CW'(1);
            if (r_decision > 0) begin
                r_minor_pos <= r_minor_down ? r_minor_pos - CW'(1) : r_minor_pos + CW'(1);
                r_decision  <= r_decision + minor2 - major2;
            end else begin
                r_decision  <= r_decision + minor2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_px   <= r_swapped ? r_minor_pos : r_major_pos;
            r_py   <= r_swapped ? r_major_pos : r_minor_pos;
            r_last <= o_stat.at_end;
        end
    end

    assign o_stat.at_end = (r_major_pos == r_major_end);
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_last_pixel  = r_last;

endmodule

// ===== hdl/line_segment_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Line segment rasterizer
// Bresenham walk of one segment per beat, one pixel beat per cycle unless
// stalled by i_m_axis_tready. A segment loads the walk registers, then each
// pixel is loaded into the output register once it is free. The single walk
// register set takes no new segment until the last pixel is loaded.
// Reset: synchronous active-low i_rst_n returns to idle with no pixel pending.
// ----------------------------------------------------------------------------
module line_segment_rasterizer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // start_x [5:0], start_y [11:6], end_x [17:12], end_y [23:18]
    input  logic [lsr_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // pixel_x [5:0], pixel_y [11:6], zero [15:12]
    output logic [lsr_pkg::OUT_W-1:0] o_m_axis_tdata,
    // last_pixel
    output logic                      o_m_axis_tlast
);

    localparam int CW = lsr_pkg::COORD_W;

    lsr_pkg::t_lsr_cmd  cmd;
    lsr_pkg::t_lsr_stat stat;
    logic [CW-1:0]      pixel_x, pixel_y;

    lsr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    lsr_dp u_dp (
        .i_clk        (i_clk),
        .i_seg        (i_s_axis_tdata),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_pixel_x    (pixel_x),
        .o_pixel_y    (pixel_y),
        .o_last_pixel (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(lsr_pkg::OUT_W - 2 * CW){1'b0}}, pixel_y, pixel_x};

endmodule
